[sv/ssrt_pkg.sv]
package ssrt_pkg;
    localparam int ENTRIES_DEF = 128;
    localparam int MAX_SEGMENTS_DEF = 6;
    localparam int MAX_PAYLOAD_DEF = 2048;
    localparam logic [7:0] TYPE_STATION = 8'hA8;
    localparam logic [7:0] TYPE_MODULE = 8'hA9;
    localparam logic [15:0] OVERHEAD = 16'd12;

    localparam logic [1:0] ST_IGNORED = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_STORED = 2'd2;
    localparam logic [1:0] ST_READOUT = 2'd3;

    typedef struct packed {
        logic [7:0]  packet_type;
        logic [15:0] channel;
        logic [7:0]  segment_count;
        logic [7:0]  segment_number;
        logic [15:0] length_field;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  slot;
        logic        kind;
        logic [15:0] message_channel;
        logic [2:0]  segment;
        logic [11:0] payload_length;
        logic        last;
    } t_out;

    // key travelling down the cell chain
    typedef struct packed {
        logic        vld;
        logic        kind;
        logic [15:0] channel;
        logic        hit;
    } t_probe;
endpackage

[sv/status_segment_reassembly_table.sv]
// One packet header per transaction. A header's kind/channel key walks down a chain of
// ENTRIES match cells, one cell per cycle, so a header of a known type presents its first
// result after the key leaves the last cell and S_FIND and S_STORE run, and S_READ too when
// it completes a message; a header of any other type presents its result in the next cycle.
// Readout of a completed message presents its segments in order. Each cell holds its
// entry's segment lengths, and the first matching cell (lowest slot) hands them down the
// chain with the key and is located by a per-cell hit scoreboard sampled as the key passes.
// No items are accepted while a header is in flight or while results remain to be delivered.
module status_segment_reassembly_table #(
    parameter int ENTRIES = ssrt_pkg::ENTRIES_DEF,
    parameter int MAX_SEGMENTS = ssrt_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_PAYLOAD = ssrt_pkg::MAX_PAYLOAD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ssrt_pkg::t_in i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ssrt_pkg::t_out o_data
);
    import ssrt_pkg::*;

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int GW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_FIND  = 6'b000100,
        S_STORE = 6'b001000,
        S_READ  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_out;
    logic   r_ovld;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_slot;
    logic [GW-1:0] r_seg;
    logic [ENTRIES-1:0] r_hits;
    logic [MAX_SEGMENTS-1:0][11:0] r_word;

    t_probe w_probe [ENTRIES+1];
    logic [MAX_SEGMENTS-1:0][11:0] w_lens [ENTRIES+1];
    logic [ENTRIES-1:0] w_used;
    logic [ENTRIES-1:0] w_wr;
    logic [ENTRIES-1:0] w_wl;
    logic   w_kind;
    logic   w_alloc;
    logic   w_full;
    logic   w_bad;
    logic   w_complete;
    logic [15:0] w_pay;
    logic [SW-1:0] w_first;
    logic [SW-1:0] w_alloc_slot;
    logic   w_any;
    logic [GW-1:0] w_num;
    logic [MAX_SEGMENTS-1:0][11:0] w_merged;
    logic [MAX_SEGMENTS-1:0][11:0] w_wr_lens;

    assign w_kind = (r_in.packet_type == TYPE_MODULE);
    assign w_probe[0] = '{vld: (r_state == S_WALK) && r_cnt == '0,
                          kind: w_kind, channel: r_in.channel, hit: 1'b0};
    assign w_lens[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign w_used[g] = CW'(g) < r_used;
        assign w_wr[g] = (r_state == S_FIND) && w_alloc && w_alloc_slot == SW'(g);
        assign w_wl[g] = (r_state == S_STORE) && !w_bad && r_slot == SW'(g);
        ssrt_cell #(
            .MAX_SEGMENTS(MAX_SEGMENTS)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_used(w_used[g]), .i_wr(w_wr[g]),
            .i_wr_kind(w_kind), .i_wr_channel(r_in.channel),
            .i_wr_len(w_wl[g]), .i_wr_lens(w_wr_lens),
            .i_probe(w_probe[g]), .i_lens(w_lens[g]),
            .o_probe(w_probe[g+1]), .o_lens(w_lens[g+1])
        );
    end

    // lowest set hit bit; hit propagates so the first cell that sets it is the leading one
    always_comb begin
        w_first = '0;
        w_any = r_hits[ENTRIES-1];
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (r_hits[k]) begin
                w_first = SW'(k);
            end
        end
    end

    assign w_alloc = !w_any;
    assign w_full = r_used >= CW'(ENTRIES);
    assign w_alloc_slot = w_full ? '0 : r_used[SW-1:0];
    assign w_pay = r_in.length_field - OVERHEAD;
    assign w_bad = r_in.segment_count > 8'(MAX_SEGMENTS) || r_in.segment_number == 8'd0 ||
                   r_in.segment_number > r_in.segment_count ||
                   r_in.length_field < OVERHEAD || w_pay > 16'(MAX_PAYLOAD);
    assign w_num = GW'(r_in.segment_number - 8'd1);

    always_comb begin
        w_merged = r_word;
        if (!w_bad) w_merged[w_num] = w_pay[11:0];
    end

    always_comb begin
        w_complete = 1'b1;
        for (int j = 0; j < MAX_SEGMENTS; j++) begin
            if (8'(j) < r_in.segment_count && w_merged[j] == '0) w_complete = 1'b0;
        end
    end

    assign w_wr_lens = w_complete ? '0 : w_merged;

    assign o_ready = (r_state == S_IDLE) && !r_ovld;
    assign o_valid = r_ovld;
    assign o_data = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid && o_ready) begin
                n_state = (i_data.packet_type == TYPE_STATION ||
                           i_data.packet_type == TYPE_MODULE) ? S_WALK : S_OUT;
            end
            S_WALK:  if (r_cnt == CW'(ENTRIES)) n_state = S_FIND;
            S_FIND:  n_state = S_STORE;
            S_STORE: n_state = (w_bad || !w_complete) ? S_OUT : S_READ;
            S_READ:  if (!r_ovld || i_ready) begin
                if (8'(r_seg) + 8'd1 == r_in.segment_count) n_state = S_OUT;
            end
            S_OUT:   if (!r_ovld || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_used  <= '0;
            r_cnt   <= '0;
            r_hits  <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovld && i_ready) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_cnt  <= '0;
                    r_hits <= '0;
                    if (i_valid && o_ready) begin
                        r_in <= i_data;
                        if (!(i_data.packet_type == TYPE_STATION ||
                              i_data.packet_type == TYPE_MODULE)) begin
                            r_out  <= '{status: ST_IGNORED, last: 1'b1, default: '0};
                            r_ovld <= 1'b1;
                        end
                    end
                end
                S_WALK: begin
                    r_cnt <= r_cnt + CW'(1);
                    for (int k = 0; k < ENTRIES; k++) begin
                        if (r_cnt == CW'(k + 1)) r_hits[k] <= w_probe[k+1].hit;
                    end
                    if (r_cnt == CW'(ENTRIES)) r_word <= w_lens[ENTRIES];
                end
                S_FIND: begin
                    if (w_alloc) begin
                        r_slot <= w_alloc_slot;
                        r_used <= w_full ? CW'(1) : r_used + CW'(1);
                        r_word <= '0;
                    end else begin
                        r_slot <= w_first;
                    end
                end
                S_STORE: begin
                    r_seg <= '0;
                    if (w_bad) begin
                        r_out  <= '{status: ST_DROPPED, slot: 7'(r_slot), kind: w_kind,
                                   message_channel: r_in.channel, last: 1'b1, default: '0};
                        r_ovld <= 1'b1;
                    end else if (!w_complete) begin
                        r_out  <= '{status: ST_STORED, slot: 7'(r_slot), kind: w_kind,
                                   message_channel: r_in.channel, segment: 3'(w_num),
                                   payload_length: w_pay[11:0], last: 1'b1};
                        r_ovld <= 1'b1;
                    end else begin
                        r_word <= w_merged;
                    end
                end
                S_READ: begin
                    if (!r_ovld || i_ready) begin
                        r_out  <= '{status: ST_READOUT, slot: 7'(r_slot), kind: w_kind,
                                   message_channel: r_in.channel, segment: 3'(r_seg),
                                   payload_length: r_word[r_seg],
                                   last: 8'(r_seg) + 8'd1 == r_in.segment_count};
                        r_ovld <= 1'b1;
                        r_seg  <= r_seg + GW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_used <= CW'(ENTRIES))
        else $error("entry count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_ready |-> !o_valid)
        else $error("accepting while a result is pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |=> (r_state == S_STORE))
        else $error("lookup did not advance to store");
endmodule

[sv/ssrt_cell.sv]
module ssrt_cell #(
    parameter int MAX_SEGMENTS = ssrt_pkg::MAX_SEGMENTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_used,
    input  logic            i_wr,
    input  logic            i_wr_kind,
    input  logic [15:0]     i_wr_channel,
    input  logic            i_wr_len,
    input  logic [MAX_SEGMENTS-1:0][11:0] i_wr_lens,
    input  ssrt_pkg::t_probe i_probe,
    input  logic [MAX_SEGMENTS-1:0][11:0] i_lens,
    output ssrt_pkg::t_probe o_probe,
    output logic [MAX_SEGMENTS-1:0][11:0] o_lens
);
    import ssrt_pkg::*;

    logic        r_kind;
    logic [15:0] r_channel;
    logic [MAX_SEGMENTS-1:0][11:0] r_lens;
    logic [MAX_SEGMENTS-1:0][11:0] r_lens_out;
    t_probe      r_probe;
    logic        w_match;

    assign w_match = i_used && r_kind == i_probe.kind && r_channel == i_probe.channel;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_kind    <= i_wr_kind;
            r_channel <= i_wr_channel;
            r_lens    <= '0;
        end else if (i_wr_len) begin
            r_lens    <= i_wr_lens;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe    <= '0;
            r_lens_out <= '0;
        end else begin
            r_probe     <= i_probe;
            r_probe.hit <= i_probe.vld && (i_probe.hit || w_match);
            r_lens_out  <= (i_probe.vld && !i_probe.hit && w_match) ? r_lens : i_lens;
        end
    end

    assign o_probe = r_probe;
    assign o_lens  = r_lens_out;
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ssrt_pkg::*;

    localparam int NSLOTS = 128;
    localparam int NSEG = 6;
    localparam int MAXPAY = 2048;
    localparam longint CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    status_segment_reassembly_table dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    // reassembly table shadow
    int unsigned used_count;
    logic entry_kind_sh[NSLOTS];
    logic [15:0] entry_chan_sh[NSLOTS];
    logic [11:0] seg_len_sh[NSLOTS][NSEG];

    t_out pending_results[$];
    int errors;
    int headers_sent;
    int results_seen;
    int readouts_seen;
    int wrap_count;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_cycles;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out make_result(logic [1:0] st, int slot, logic kd, logic [15:0] ch,
                                         int seg, logic [11:0] len, logic lst);
        t_out r;
        r.status = st;
        r.slot = slot[6:0];
        r.kind = kd;
        r.message_channel = ch;
        r.segment = seg[2:0];
        r.payload_length = len;
        r.last = lst;
        return r;
    endfunction

    task automatic predict_header(input t_in h);
        logic kd;
        int slot;
        int cnt;
        int num;
        int lf;
        bit full;
        if (h.packet_type != TYPE_STATION && h.packet_type != TYPE_MODULE) begin
            pending_results.push_back(make_result(ST_IGNORED, 0, 1'b0, 16'h0, 0, 12'h0, 1'b1));
            return;
        end
        kd = (h.packet_type == TYPE_MODULE);
        slot = used_count;
        for (int s = 0; s < used_count; s++) begin
            if (entry_chan_sh[s] == h.channel && entry_kind_sh[s] == kd) begin
                slot = s;
                break;
            end
        end
        if (slot == used_count) begin
            if (used_count >= NSLOTS) begin
                used_count = 0;
                slot = 0;
                wrap_count++;
            end
            entry_kind_sh[slot] = kd;
            entry_chan_sh[slot] = h.channel;
            for (int j = 0; j < NSEG; j++) seg_len_sh[slot][j] = '0;
            used_count++;
        end
        cnt = h.segment_count;
        num = h.segment_number;
        lf = h.length_field;
        if (cnt > NSEG || num == 0 || num > cnt || lf < 12 || lf - 12 > MAXPAY) begin
            pending_results.push_back(make_result(ST_DROPPED, slot, kd, h.channel, 0, 12'h0, 1'b1));
            return;
        end
        seg_len_sh[slot][num - 1] = 12'(lf - 12);
        full = 1'b1;
        for (int j = 0; j < cnt; j++) if (seg_len_sh[slot][j] == 0) full = 1'b0;
        if (!full) begin
            pending_results.push_back(make_result(ST_STORED, slot, kd, h.channel, num - 1,
                                                  12'(lf - 12), 1'b1));
            return;
        end
        for (int j = 0; j < cnt; j++)
            pending_results.push_back(make_result(ST_READOUT, slot, kd, h.channel, j,
                                                  seg_len_sh[slot][j], j == cnt - 1));
        for (int j = 0; j < NSEG; j++) seg_len_sh[slot][j] = '0;
    endtask

    task automatic send_header(input t_in h);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid <= 1'b1;
        i_data <= h;
        do @(posedge i_clk); while (!o_ready);
        predict_header(h);
        headers_sent++;
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in header(logic [7:0] ty, logic [15:0] ch, int cnt, int num, int lf);
        t_in h;
        h.packet_type = ty;
        h.channel = ch;
        h.segment_count = cnt[7:0];
        h.segment_number = num[7:0];
        h.length_field = lf[15:0];
        return h;
    endfunction

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (recv_hold_cycles > 0) begin
                recv_hold_cycles <= recv_hold_cycles - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result %p", o_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.status == ST_READOUT) readouts_seen++;
                if (o_data.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, o_data.status);
                    errors++;
                end
                if (o_data.slot !== want.slot) begin
                    $error("slot expected %0d got %0d", want.slot, o_data.slot);
                    errors++;
                end
                if (o_data.kind !== want.kind) begin
                    $error("kind expected %0d got %0d", want.kind, o_data.kind);
                    errors++;
                end
                if (o_data.message_channel !== want.message_channel) begin
                    $error("message_channel expected %h got %h", want.message_channel,
                           o_data.message_channel);
                    errors++;
                end
                if (o_data.segment !== want.segment) begin
                    $error("segment expected %0d got %0d", want.segment, o_data.segment);
                    errors++;
                end
                if (o_data.payload_length !== want.payload_length) begin
                    $error("payload_length expected %0d got %0d", want.payload_length,
                           o_data.payload_length);
                    errors++;
                end
                if (o_data.last !== want.last) begin
                    $error("last expected %0d got %0d", want.last, o_data.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        send_header(header(8'h00, 16'hFFFF, 1, 1, 100));
        send_header(header(8'hFF, 16'h0000, 0, 0, 0));
        send_header(header(8'hA8, 16'h0000, 1, 1, 12));
        send_header(header(8'hA8, 16'h0000, 1, 1, 13));
        send_header(header(8'hA9, 16'hFFFF, 1, 1, 2060));
        send_header(header(8'hA9, 16'hFFFF, 1, 1, 2061));
        send_header(header(8'hA9, 16'hFFFF, 1, 1, 11));
        send_header(header(8'hA9, 16'hFFFF, 1, 1, 16'hFFFF));
        send_header(header(8'hA8, 16'h1234, 7, 1, 100));
        send_header(header(8'hA8, 16'h1234, 255, 255, 100));
        send_header(header(8'hA8, 16'h1234, 3, 0, 100));
        send_header(header(8'hA8, 16'h1234, 3, 4, 100));
        send_header(header(8'hA8, 16'h1234, 6, 6, 40));
        send_header(header(8'hA8, 16'h1234, 6, 1, 41));
        send_header(header(8'hA8, 16'h1234, 6, 2, 42));
        send_header(header(8'hA8, 16'h1234, 6, 3, 43));
        send_header(header(8'hA8, 16'h1234, 6, 4, 44));
        send_header(header(8'hA8, 16'h1234, 6, 5, 2060));
        send_header(header(8'hA9, 16'h1234, 2, 1, 50));
        send_header(header(8'hA9, 16'h1234, 2, 2, 12));
        send_header(header(8'hA9, 16'h1234, 2, 2, 60));
        send_header(header(8'hA9, 16'h1234, 2, 1, 70));
        drain_results();
    endtask

    task automatic send_message(logic kd, logic [15:0] ch);
        int cnt;
        int order[NSEG];
        int k;
        int t;
        cnt = $urandom_range(NSEG, 1);
        for (int j = 0; j < NSEG; j++) order[j] = j + 1;
        for (int j = cnt - 1; j > 0; j--) begin
            k = $urandom_range(j);
            t = order[j];
            order[j] = order[k];
            order[k] = t;
        end
        for (int j = 0; j < cnt; j++)
            send_header(header(kd ? TYPE_MODULE : TYPE_STATION, ch, cnt, order[j],
                               $urandom_range(2060, 13)));
    endtask

    task automatic send_noise();
        t_in h;
        h = t_in'(56'({$urandom, $urandom}));
        case ($urandom_range(3))
            0: h.packet_type = TYPE_STATION;
            1: h.packet_type = TYPE_MODULE;
            default: ;
        endcase
        send_header(h);
    endtask

    task automatic test_random(int n);
        int stop_at;
        stop_at = headers_sent + n;
        while (headers_sent < stop_at) begin
            if ($urandom_range(9) < 7)
                send_message(1'($urandom_range(1)), 16'($urandom_range(7)) ^
                             ($urandom_range(1) ? 16'hFFF0 : 16'h0));
            else
                send_noise();
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        recv_hold_cycles = 400;
        for (int j = 0; j < 6; j++) send_header(header(TYPE_MODULE, 16'h00AA, 6, j + 1, 100 + j));
        recv_hold_cycles = 400;
        send_message(1'b0, 16'h0055);
        drain_results();
    endtask

    task automatic test_table_full();
        send_header(header(TYPE_STATION, 16'hBEEF, 2, 1, 30));
        for (int j = 0; j < NSLOTS + 2; j++)
            send_header(header(TYPE_STATION, 16'(16'h8000 + j), 1, $urandom_range(1), 20));
        send_header(header(TYPE_STATION, 16'hBEEF, 2, 2, 30));
        drain_results();
    endtask

    initial begin
        errors = 0;
        headers_sent = 0;
        results_seen = 0;
        readouts_seen = 0;
        wrap_count = 0;
        used_count = 0;
        cycle_count = 0;
        recv_hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 59;
        test_directed();
        test_random(15);
        send_idle_pct = 59;
        recv_idle_pct = 16;
        test_random(15);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(10);
        test_table_full();

        drain_results();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d headers, %0d results (%0d readout), %0d table wraps.",
                 headers_sent, results_seen, readouts_seen, wrap_count);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

[sim.f]
sv/ssrt_pkg.sv
sv/ssrt_cell.sv
sv/status_segment_reassembly_table.sv
tb/tb_top.sv
